### sv/rdl_pkg.sv
package rdl_pkg;

    localparam int LEVEL_BITS     = 16;
    localparam int TIME_BITS      = 32;
    localparam int CMD_BITS       = 2;
    localparam int DELTA_BITS     = 2;
    localparam int PRESET_BITS    = LEVEL_BITS + 1;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = PRESET_BITS;
    localparam int MAG_BITS       = LEVEL_BITS + 3;
    localparam int SUM_BITS       = LEVEL_BITS + 6;

    localparam logic [TIME_BITS-1:0]  FAST_GAP_MS  = TIME_BITS'(30);
    localparam logic [TIME_BITS-1:0]  MED_GAP_MS   = TIME_BITS'(80);
    localparam logic [LEVEL_BITS-1:0] DEFAULT_LOW  = LEVEL_BITS'(0);
    localparam logic [LEVEL_BITS-1:0] DEFAULT_HIGH = LEVEL_BITS'(100);

    localparam logic [LEVEL_BITS-1:0]  RESET_MIN_LEVEL = LEVEL_BITS'(0);
    localparam logic [LEVEL_BITS-1:0]  RESET_MAX_LEVEL = LEVEL_BITS'(100);
    localparam logic [LEVEL_BITS-1:0]  RESET_STEP_SIZE = LEVEL_BITS'(1);
    localparam logic [PRESET_BITS-1:0] PRESET_UNSET    = '1;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ROTATE = 2'd0,
        CMD_CLICK  = 2'd1,
        CMD_DOUBLE = 2'd2,
        CMD_LONG   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MIN_LEVEL    = 3'd0,
        CFG_MAX_LEVEL    = 3'd1,
        CFG_STEP_SIZE    = 3'd2,
        CFG_ACCEL_ENABLE = 3'd3,
        CFG_DBL_PRESET   = 3'd4,
        CFG_HOLD_PRESET  = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        OP_ROTATE = 2'd0,
        OP_TOGGLE = 2'd1,
        OP_JUMP   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ACCEL_X1 = 2'd0,
        ACCEL_X2 = 2'd1,
        ACCEL_X4 = 2'd2
    } accel_t;

    typedef enum logic {
        KIND_LEVEL  = 1'b0,
        KIND_SWITCH = 1'b1
    } send_kind_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0]  min_level;
        logic [LEVEL_BITS-1:0]  max_level;
        logic [LEVEL_BITS-1:0]  step_size;
        logic                   accel_enable;
        logic [PRESET_BITS-1:0] dbl_preset;
        logic [PRESET_BITS-1:0] hold_preset;
    } cfg_t;

    typedef struct packed {
        op_t                          op;
        logic signed [DELTA_BITS-1:0] delta;
        accel_t                       accel;
        logic [LEVEL_BITS-1:0]        target;
    } job_t;

endpackage

### sv/rdl_ifs.sv
interface rdl_evt_if;
    logic                                 valid;
    logic                                 ready;
    logic [rdl_pkg::CMD_BITS-1:0]         command;
    logic signed [rdl_pkg::DELTA_BITS-1:0] delta;
    logic [rdl_pkg::TIME_BITS-1:0]        timestamp_ms;

    modport source (output valid, output command, output delta, output timestamp_ms,
                    input ready);
    modport sink   (input valid, input command, input delta, input timestamp_ms,
                    output ready);
endinterface

interface rdl_res_if;
    logic                           valid;
    logic                           ready;
    logic                           send_kind;
    logic [rdl_pkg::LEVEL_BITS-1:0] level;
    logic                           on_state;

    modport source (output valid, output send_kind, output level, output on_state,
                    input ready);
    modport sink   (input valid, input send_kind, input level, input on_state,
                    output ready);
endinterface

interface rdl_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rdl_pkg::CFG_INDEX_BITS-1:0] index;
    logic [rdl_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/rdl_front.sv
module rdl_front (
    input  logic                clk,
    input  logic                rst_n,
    input  rdl_pkg::cfg_t       cfg,
    rdl_evt_if.sink             evt,
    output logic                job_valid,
    input  logic                job_ready,
    output rdl_pkg::job_t       job
);

    logic [rdl_pkg::TIME_BITS-1:0] last_time_reg;
    logic [rdl_pkg::TIME_BITS-1:0] last_time_next;
    logic [rdl_pkg::TIME_BITS-1:0] gap;
    rdl_pkg::cmd_t                 cmd;
    rdl_pkg::accel_t               accel;
    logic [rdl_pkg::PRESET_BITS-1:0] preset;
    logic                          keep;
    logic                          accept;

    assign evt.ready = job_ready;
    assign accept    = evt.valid && job_ready;
    assign cmd       = rdl_pkg::cmd_t'(evt.command);
    assign gap       = evt.timestamp_ms - last_time_reg;

    always_comb
    begin
        accel = rdl_pkg::ACCEL_X1;
        if (cfg.accel_enable && (last_time_reg != '0))
        begin
            if (evt.timestamp_ms < last_time_reg)
            begin
                accel = rdl_pkg::ACCEL_X4;
            end
            else if (gap <= rdl_pkg::FAST_GAP_MS)
            begin
                accel = rdl_pkg::ACCEL_X4;
            end
            else if (gap <= rdl_pkg::MED_GAP_MS)
            begin
                accel = rdl_pkg::ACCEL_X2;
            end
        end
    end

    always_comb
    begin
        job.delta  = evt.delta;
        job.accel  = accel;
        job.op     = rdl_pkg::OP_JUMP;
        preset     = cfg.hold_preset;
        keep       = 1'b1;
        unique case (cmd)
            rdl_pkg::CMD_ROTATE: job.op = rdl_pkg::OP_ROTATE;
            rdl_pkg::CMD_CLICK:  job.op = rdl_pkg::OP_TOGGLE;
            rdl_pkg::CMD_DOUBLE: preset = cfg.dbl_preset;
            default:             preset = cfg.hold_preset;
        endcase
        if ((job.op == rdl_pkg::OP_JUMP) && preset[rdl_pkg::PRESET_BITS-1])
        begin
            keep = 1'b0;
        end
        job.target = preset[rdl_pkg::LEVEL_BITS-1:0];
    end

    assign job_valid = evt.valid && keep;

    always_comb
    begin
        last_time_next = last_time_reg;
        if (accept && (cmd == rdl_pkg::CMD_ROTATE))
        begin
            last_time_next = evt.timestamp_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
        end
        else
        begin
            last_time_reg <= last_time_next;
        end
    end

endmodule

### sv/rdl_job_fifo.sv
module rdl_job_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  rdl_pkg::job_t wr_job,
    output logic          rd_valid,
    input  logic          rd_ready,
    output rdl_pkg::job_t rd_job
);

    rdl_pkg::job_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          push;
    logic          pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_job   = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

### sv/rdl_back.sv
module rdl_back (
    input  logic          clk,
    input  logic          rst_n,
    input  rdl_pkg::cfg_t cfg,
    input  logic          job_valid,
    output logic          job_ready,
    input  rdl_pkg::job_t job,
    rdl_res_if.source     res
);

    logic [rdl_pkg::LEVEL_BITS-1:0]      level_reg;
    logic [rdl_pkg::LEVEL_BITS-1:0]      level_next;
    logic                                on_reg;
    logic                                on_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic                                out_kind_reg;
    logic                                out_kind_next;
    logic [rdl_pkg::LEVEL_BITS-1:0]      out_level_reg;
    logic [rdl_pkg::LEVEL_BITS-1:0]      out_level_next;
    logic                                out_on_reg;
    logic                                out_on_next;

    logic                                pop;
    logic [rdl_pkg::LEVEL_BITS-1:0]      lo;
    logic [rdl_pkg::LEVEL_BITS-1:0]      hi;
    logic [rdl_pkg::LEVEL_BITS-1:0]      step;
    logic [rdl_pkg::MAG_BITS-1:0]        mag;
    logic signed [rdl_pkg::SUM_BITS-1:0] mag_ext;
    logic signed [rdl_pkg::SUM_BITS-1:0] incr;
    logic signed [rdl_pkg::SUM_BITS-1:0] value;
    logic signed [rdl_pkg::SUM_BITS-1:0] lo_ext;
    logic signed [rdl_pkg::SUM_BITS-1:0] hi_ext;
    logic [rdl_pkg::LEVEL_BITS-1:0]      clamped;

    assign job_ready     = !out_valid_reg || res.ready;
    assign pop           = job_valid && job_ready;
    assign res.valid     = out_valid_reg;
    assign res.send_kind = out_kind_reg;
    assign res.level     = out_level_reg;
    assign res.on_state  = out_on_reg;

    // A range with max not above min falls back to the default span.
    always_comb
    begin
        if (cfg.max_level <= cfg.min_level)
        begin
            lo = rdl_pkg::DEFAULT_LOW;
            hi = rdl_pkg::DEFAULT_HIGH;
        end
        else
        begin
            lo = cfg.min_level;
            hi = cfg.max_level;
        end
    end

    always_comb
    begin
        step = (cfg.step_size == '0) ? rdl_pkg::LEVEL_BITS'(1) : cfg.step_size;
        case (job.accel)
            rdl_pkg::ACCEL_X2: mag = rdl_pkg::MAG_BITS'(step) << 1;
            rdl_pkg::ACCEL_X4: mag = rdl_pkg::MAG_BITS'(step) << 2;
            default:           mag = rdl_pkg::MAG_BITS'(step);
        endcase
        mag_ext = $signed({{(rdl_pkg::SUM_BITS - rdl_pkg::MAG_BITS){1'b0}}, mag});
        case (job.delta)
            2'sb01:  incr = mag_ext;
            2'sb11:  incr = -mag_ext;
            2'sb10:  incr = -(mag_ext <<< 1);
            default: incr = '0;
        endcase
    end

    always_comb
    begin
        lo_ext = $signed({{(rdl_pkg::SUM_BITS - rdl_pkg::LEVEL_BITS){1'b0}}, lo});
        hi_ext = $signed({{(rdl_pkg::SUM_BITS - rdl_pkg::LEVEL_BITS){1'b0}}, hi});
        if (job.op == rdl_pkg::OP_ROTATE)
        begin
            value = $signed({{(rdl_pkg::SUM_BITS - rdl_pkg::LEVEL_BITS){1'b0}}, level_reg})
                    + incr;
        end
        else
        begin
            value = $signed({{(rdl_pkg::SUM_BITS - rdl_pkg::LEVEL_BITS){1'b0}}, job.target});
        end
        if (value < lo_ext)
        begin
            clamped = lo;
        end
        else if (value > hi_ext)
        begin
            clamped = hi;
        end
        else
        begin
            clamped = value[rdl_pkg::LEVEL_BITS-1:0];
        end
    end

    always_comb
    begin
        level_next     = level_reg;
        on_next        = on_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_kind_next  = out_kind_reg;
        out_level_next = out_level_reg;
        out_on_next    = out_on_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            if (job.op == rdl_pkg::OP_TOGGLE)
            begin
                on_next        = !on_reg;
                out_kind_next  = rdl_pkg::KIND_SWITCH;
                out_level_next = level_reg;
                out_on_next    = !on_reg;
            end
            else
            begin
                level_next     = clamped;
                on_next        = clamped > lo;
                out_kind_next  = rdl_pkg::KIND_LEVEL;
                out_level_next = clamped;
                out_on_next    = clamped > lo;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            on_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg     <= level_next;
            on_reg        <= on_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg  <= out_kind_next;
        out_level_reg <= out_level_next;
        out_on_reg    <= out_on_next;
    end

endmodule

### sv/rotary_dimmer_level_control_core.sv
// Knob event processor for a dimmer: rotate, click, double click and long press requests
// update a stored level and on flag, with time-based step acceleration on rotates. The
// block accepts one request per clock cycle while the queue has room. A request passes
// through a two-entry queue, which separates the classifying front from the level update,
// then through the output register, which can refill in the cycle its result is taken.
// Double click and long press requests with an unset preset produce no result.
module rotary_dimmer_level_control_core (
    input  logic      clk,
    input  logic      rst_n,
    rdl_cfg_if.sink   cfg,
    rdl_evt_if.sink   evt,
    rdl_res_if.source res
);

    rdl_pkg::cfg_t cfg_reg;
    rdl_pkg::cfg_t cfg_next;

    logic          front_valid;
    logic          front_ready;
    rdl_pkg::job_t front_job;
    logic          job_valid;
    logic          job_ready;
    rdl_pkg::job_t job;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (rdl_pkg::cfg_index_t'(cfg.index))
                rdl_pkg::CFG_MIN_LEVEL:
                    cfg_next.min_level = cfg.data[rdl_pkg::LEVEL_BITS-1:0];
                rdl_pkg::CFG_MAX_LEVEL:
                    cfg_next.max_level = cfg.data[rdl_pkg::LEVEL_BITS-1:0];
                rdl_pkg::CFG_STEP_SIZE:
                    cfg_next.step_size = cfg.data[rdl_pkg::LEVEL_BITS-1:0];
                rdl_pkg::CFG_ACCEL_ENABLE:
                    cfg_next.accel_enable = cfg.data[0];
                rdl_pkg::CFG_DBL_PRESET:
                    cfg_next.dbl_preset = cfg.data;
                rdl_pkg::CFG_HOLD_PRESET:
                    cfg_next.hold_preset = cfg.data;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_level    <= rdl_pkg::RESET_MIN_LEVEL;
            cfg_reg.max_level    <= rdl_pkg::RESET_MAX_LEVEL;
            cfg_reg.step_size    <= rdl_pkg::RESET_STEP_SIZE;
            cfg_reg.accel_enable <= 1'b0;
            cfg_reg.dbl_preset   <= rdl_pkg::PRESET_UNSET;
            cfg_reg.hold_preset  <= rdl_pkg::PRESET_UNSET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rdl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .evt       (evt),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    rdl_job_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_job   (front_job),
        .rd_valid (job_valid),
        .rd_ready (job_ready),
        .rd_job   (job)
    );

    rdl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .res       (res)
    );

    a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && job_ready |=> res.valid)
        else $error("Queued request did not produce a result.");

    a_rotate_queued: assert property (@(posedge clk) disable iff (!rst_n)
        evt.valid && evt.ready && (evt.command == rdl_pkg::CMD_ROTATE) |=> job_valid)
        else $error("Accepted rotate request missing from the queue.");

    a_stalled_job_kept: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && !job_ready |=> job_valid)
        else $error("Queue lost a request while the back end stalled.");

endmodule

### dv/rotary_dimmer_level_control_core_tb.sv
module rotary_dimmer_level_control_core_tb;

    localparam int FAST_FACTOR   = 4;
    localparam int MED_FACTOR    = 2;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int ITEM_TARGET   = 1800;

    typedef struct packed {
        rdl_pkg::send_kind_t            kind;
        logic [rdl_pkg::LEVEL_BITS-1:0] level;
        logic                           on_state;
    } dimmer_report_t;

    typedef struct {
        bit                                reg_is_cfg;
        rdl_pkg::cfg_index_t               reg_idx;
        logic [rdl_pkg::CFG_DATA_BITS-1:0] reg_val;
        rdl_pkg::cmd_t                     cmd;
        logic [rdl_pkg::DELTA_BITS-1:0]    delta;
        logic [rdl_pkg::TIME_BITS-1:0]     ts;
        bit                                known;
        bit                                known_none;
        dimmer_report_t                    report;
    } knob_row_t;

    logic clk;
    logic rst_n;

    rdl_cfg_if cfg_bus ();
    rdl_evt_if evt_bus ();
    rdl_res_if res_bus ();

    rotary_dimmer_level_control_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .evt   (evt_bus),
        .res   (res_bus)
    );

    rdl_pkg::cfg_t                  shadow_cfg;
    logic [rdl_pkg::LEVEL_BITS-1:0] level_now;
    logic                           on_now;
    logic [rdl_pkg::TIME_BITS-1:0]  last_turn_ms;

    dimmer_report_t pending_reports[$];
    knob_row_t      directed_rows[$];

    int mismatches;
    int items_sent;
    bit no_idle;

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic logic [rdl_pkg::LEVEL_BITS-1:0] pick_level();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return rdl_pkg::LEVEL_BITS'($urandom_range(0, 20));
            3: return rdl_pkg::LEVEL_BITS'($urandom_range(0, 300));
            4: return rdl_pkg::LEVEL_BITS'($urandom);
            default: return rdl_pkg::LEVEL_BITS'($urandom_range(20, 150));
        endcase
    endfunction

    function automatic logic [rdl_pkg::PRESET_BITS-1:0] pick_preset();
        case ($urandom_range(0, 7))
            0, 1: return rdl_pkg::PRESET_UNSET;
            2: return {1'b1, rdl_pkg::LEVEL_BITS'($urandom)};
            default: return {1'b0, pick_level()};
        endcase
    endfunction

    function automatic void apply_reg(input rdl_pkg::cfg_index_t idx,
                                      input logic [rdl_pkg::CFG_DATA_BITS-1:0] val);
        case (idx)
            rdl_pkg::CFG_MIN_LEVEL:    shadow_cfg.min_level = val[rdl_pkg::LEVEL_BITS-1:0];
            rdl_pkg::CFG_MAX_LEVEL:    shadow_cfg.max_level = val[rdl_pkg::LEVEL_BITS-1:0];
            rdl_pkg::CFG_STEP_SIZE:    shadow_cfg.step_size = val[rdl_pkg::LEVEL_BITS-1:0];
            rdl_pkg::CFG_ACCEL_ENABLE: shadow_cfg.accel_enable = val[0];
            rdl_pkg::CFG_DBL_PRESET:   shadow_cfg.dbl_preset = val[rdl_pkg::PRESET_BITS-1:0];
            rdl_pkg::CFG_HOLD_PRESET:  shadow_cfg.hold_preset = val[rdl_pkg::PRESET_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic void land_level(input longint v, input int lo, input int hi,
                                       output dimmer_report_t r);
        longint clamped;
        clamped = (v < lo) ? lo : ((v > hi) ? hi : v);
        level_now = clamped[rdl_pkg::LEVEL_BITS-1:0];
        on_now = clamped > lo;
        r.kind = rdl_pkg::KIND_LEVEL;
        r.level = level_now;
        r.on_state = on_now;
    endfunction

    // Updates the level state for one request and returns 1 when a result is due.
    function automatic bit predict_report(input rdl_pkg::cmd_t c,
                                          input logic signed [rdl_pkg::DELTA_BITS-1:0] d,
                                          input logic [rdl_pkg::TIME_BITS-1:0] ts,
                                          output dimmer_report_t r);
        int lo;
        int hi;
        longint step;
        longint factor;
        logic [rdl_pkg::PRESET_BITS-1:0] target;
        r = '0;
        if (shadow_cfg.max_level <= shadow_cfg.min_level)
        begin
            lo = int'(rdl_pkg::DEFAULT_LOW);
            hi = int'(rdl_pkg::DEFAULT_HIGH);
        end
        else
        begin
            lo = int'(shadow_cfg.min_level);
            hi = int'(shadow_cfg.max_level);
        end
        case (c)
            rdl_pkg::CMD_ROTATE:
            begin
                step = (shadow_cfg.step_size == '0) ? 1 : longint'(shadow_cfg.step_size);
                factor = 1;
                if (shadow_cfg.accel_enable && last_turn_ms != '0)
                begin
                    if (ts < last_turn_ms || ts - last_turn_ms <= rdl_pkg::FAST_GAP_MS)
                        factor = FAST_FACTOR;
                    else if (ts - last_turn_ms <= rdl_pkg::MED_GAP_MS)
                        factor = MED_FACTOR;
                end
                last_turn_ms = ts;
                land_level(longint'(level_now) + longint'(d) * step * factor, lo, hi, r);
                return 1'b1;
            end
            rdl_pkg::CMD_CLICK:
            begin
                on_now = !on_now;
                r.kind = rdl_pkg::KIND_SWITCH;
                r.level = level_now;
                r.on_state = on_now;
                return 1'b1;
            end
            default:
            begin
                target = (c == rdl_pkg::CMD_DOUBLE) ? shadow_cfg.dbl_preset
                                                    : shadow_cfg.hold_preset;
                if (target[rdl_pkg::PRESET_BITS-1])
                    return 1'b0;
                land_level(longint'(target), lo, hi, r);
                return 1'b1;
            end
        endcase
    endfunction

    function automatic knob_row_t blank_row();
        knob_row_t row;
        row.reg_is_cfg = 1'b0;
        row.reg_idx = rdl_pkg::CFG_MIN_LEVEL;
        row.reg_val = '0;
        row.cmd = rdl_pkg::CMD_ROTATE;
        row.delta = '0;
        row.ts = '0;
        row.known = 1'b0;
        row.known_none = 1'b0;
        row.report = '0;
        return row;
    endfunction

    function automatic void row_cfg(input rdl_pkg::cfg_index_t idx,
                                    input logic [rdl_pkg::CFG_DATA_BITS-1:0] val);
        knob_row_t row;
        row = blank_row();
        row.reg_is_cfg = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        directed_rows.push_back(row);
    endfunction

    function automatic void row_evt(input rdl_pkg::cmd_t c,
                                    input logic [rdl_pkg::DELTA_BITS-1:0] d,
                                    input logic [rdl_pkg::TIME_BITS-1:0] ts);
        knob_row_t row;
        row = blank_row();
        row.cmd = c;
        row.delta = d;
        row.ts = ts;
        directed_rows.push_back(row);
    endfunction

    function automatic void row_known(input rdl_pkg::cmd_t c,
                                      input logic [rdl_pkg::DELTA_BITS-1:0] d,
                                      input logic [rdl_pkg::TIME_BITS-1:0] ts, input bit none,
                                      input rdl_pkg::send_kind_t kind,
                                      input logic [rdl_pkg::LEVEL_BITS-1:0] lvl,
                                      input logic on_state);
        knob_row_t row;
        row = blank_row();
        row.cmd = c;
        row.delta = d;
        row.ts = ts;
        row.known = 1'b1;
        row.known_none = none;
        row.report.kind = kind;
        row.report.level = lvl;
        row.report.on_state = on_state;
        directed_rows.push_back(row);
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic push_request(input rdl_pkg::cmd_t c,
                                input logic [rdl_pkg::DELTA_BITS-1:0] d,
                                input logic [rdl_pkg::TIME_BITS-1:0] ts);
        int gap;
        gap = idle_draw();
        if (gap > 0)
        begin
            evt_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_bus.valid <= 1'b1;
        evt_bus.command <= c;
        evt_bus.delta <= d;
        evt_bus.timestamp_ms <= ts;
        do @(posedge clk); while (!evt_bus.ready);
    endtask

    task automatic write_reg(input rdl_pkg::cfg_index_t idx,
                             input logic [rdl_pkg::CFG_DATA_BITS-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= val;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        apply_reg(idx, val);
        @(posedge clk);
    endtask

    // A jump with an unset preset leaves nothing in the queue, so extra cycles
    // are allowed for such a request to pass through the pipeline.
    task automatic wait_quiet();
        evt_bus.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : result_sink
        int stall;
        dimmer_report_t want;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = idle_draw();
            if (stall > 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge clk); while (!res_bus.valid);
            if (pending_reports.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result kind=%0d level=%0d on=%0b",
                                        res_bus.send_kind, res_bus.level, res_bus.on_state));
            end
            else
            begin
                want = pending_reports.pop_front();
                if (res_bus.send_kind !== want.kind)
                    flag_mismatch($sformatf("send_kind got %0d want %0d",
                                            res_bus.send_kind, want.kind));
                if (res_bus.level !== want.level)
                    flag_mismatch($sformatf("level got %0d want %0d",
                                            res_bus.level, want.level));
                if (res_bus.on_state !== want.on_state)
                    flag_mismatch($sformatf("on_state got %0b want %0b",
                                            res_bus.on_state, want.on_state));
            end
        end
    end

    initial
    begin : stimulus
        int phase_len;
        int sel;
        bit got;
        dimmer_report_t r;
        rdl_pkg::cmd_t c;
        logic [rdl_pkg::DELTA_BITS-1:0] d;
        logic [rdl_pkg::TIME_BITS-1:0] knob_clock;

        rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        evt_bus.valid = 1'b0;
        evt_bus.command = '0;
        evt_bus.delta = '0;
        evt_bus.timestamp_ms = '0;
        res_bus.ready = 1'b0;
        mismatches = 0;
        items_sent = 0;
        no_idle = 1'b0;
        knob_clock = '0;

        shadow_cfg.min_level = rdl_pkg::RESET_MIN_LEVEL;
        shadow_cfg.max_level = rdl_pkg::RESET_MAX_LEVEL;
        shadow_cfg.step_size = rdl_pkg::RESET_STEP_SIZE;
        shadow_cfg.accel_enable = 1'b0;
        shadow_cfg.dbl_preset = rdl_pkg::PRESET_UNSET;
        shadow_cfg.hold_preset = rdl_pkg::PRESET_UNSET;
        level_now = '0;
        on_now = 1'b0;
        last_turn_ms = '0;

        row_known(rdl_pkg::CMD_CLICK, 2'b00, 0, 0, rdl_pkg::KIND_SWITCH, 0, 1'b1);
        row_known(rdl_pkg::CMD_CLICK, 2'b00, 0, 0, rdl_pkg::KIND_SWITCH, 0, 1'b0);
        row_known(rdl_pkg::CMD_DOUBLE, 2'b00, 0, 1, rdl_pkg::KIND_LEVEL, 0, 1'b0);
        row_known(rdl_pkg::CMD_LONG, 2'b00, 0, 1, rdl_pkg::KIND_LEVEL, 0, 1'b0);
        row_known(rdl_pkg::CMD_ROTATE, 2'b11, 0, 0, rdl_pkg::KIND_LEVEL, 0, 1'b0);
        row_known(rdl_pkg::CMD_ROTATE, 2'b01, 0, 0, rdl_pkg::KIND_LEVEL, 1, 1'b1);
        row_known(rdl_pkg::CMD_ROTATE, 2'b00, 5, 0, rdl_pkg::KIND_LEVEL, 1, 1'b1);
        row_known(rdl_pkg::CMD_ROTATE, 2'b10, 10, 0, rdl_pkg::KIND_LEVEL, 0, 1'b0);
        row_cfg(rdl_pkg::CFG_MAX_LEVEL, 17'h0FFFF);
        row_cfg(rdl_pkg::CFG_STEP_SIZE, 17'h0FFFF);
        row_known(rdl_pkg::CMD_ROTATE, 2'b01, 100, 0, rdl_pkg::KIND_LEVEL, 16'hFFFF, 1'b1);
        row_known(rdl_pkg::CMD_ROTATE, 2'b01, 200, 0, rdl_pkg::KIND_LEVEL, 16'hFFFF, 1'b1);
        row_cfg(rdl_pkg::CFG_ACCEL_ENABLE, 17'd1);
        row_cfg(rdl_pkg::CFG_STEP_SIZE, 17'd1000);
        row_evt(rdl_pkg::CMD_ROTATE, 2'b11, 220);
        row_evt(rdl_pkg::CMD_ROTATE, 2'b11, 300);
        row_evt(rdl_pkg::CMD_ROTATE, 2'b11, 381);
        row_evt(rdl_pkg::CMD_ROTATE, 2'b01, 100);
        row_evt(rdl_pkg::CMD_ROTATE, 2'b11, 32'hFFFF_FFFF);
        row_cfg(rdl_pkg::CFG_DBL_PRESET, 17'd0);
        row_cfg(rdl_pkg::CFG_HOLD_PRESET, 17'h0FFFF);
        row_known(rdl_pkg::CMD_DOUBLE, 2'b00, 0, 0, rdl_pkg::KIND_LEVEL, 0, 1'b0);
        row_known(rdl_pkg::CMD_LONG, 2'b00, 0, 0, rdl_pkg::KIND_LEVEL, 16'hFFFF, 1'b1);
        row_cfg(rdl_pkg::CFG_MIN_LEVEL, 17'd500);
        row_cfg(rdl_pkg::CFG_MAX_LEVEL, 17'd400);
        row_known(rdl_pkg::CMD_CLICK, 2'b00, 0, 0, rdl_pkg::KIND_SWITCH, 16'hFFFF, 1'b0);
        row_known(rdl_pkg::CMD_ROTATE, 2'b00, 0, 0, rdl_pkg::KIND_LEVEL, 100, 1'b1);
        row_known(rdl_pkg::CMD_LONG, 2'b00, 0, 0, rdl_pkg::KIND_LEVEL, 100, 1'b1);
        row_cfg(rdl_pkg::CFG_STEP_SIZE, 17'd0);
        row_cfg(rdl_pkg::CFG_MIN_LEVEL, 17'd10);
        row_cfg(rdl_pkg::CFG_MAX_LEVEL, 17'd20);
        row_cfg(rdl_pkg::CFG_HOLD_PRESET, rdl_pkg::PRESET_UNSET);
        row_known(rdl_pkg::CMD_ROTATE, 2'b01, 5, 0, rdl_pkg::KIND_LEVEL, 20, 1'b1);
        row_evt(rdl_pkg::CMD_ROTATE, 2'b11, 1000);
        row_known(rdl_pkg::CMD_LONG, 2'b00, 0, 1, rdl_pkg::KIND_LEVEL, 0, 1'b0);
        row_known(rdl_pkg::CMD_DOUBLE, 2'b00, 0, 0, rdl_pkg::KIND_LEVEL, 10, 1'b0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].reg_is_cfg)
            begin
                wait_quiet();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
            begin
                push_request(directed_rows[i].cmd, directed_rows[i].delta, directed_rows[i].ts);
                got = predict_report(directed_rows[i].cmd, directed_rows[i].delta,
                                     directed_rows[i].ts, r);
                if (directed_rows[i].known)
                begin
                    got = !directed_rows[i].known_none;
                    r = directed_rows[i].report;
                end
                if (got)
                    pending_reports.push_back(r);
            end
        end

        while (items_sent < ITEM_TARGET)
        begin
            wait_quiet();
            if ($urandom_range(0, 1))
                write_reg(rdl_pkg::CFG_MIN_LEVEL, {1'b0, pick_level()});
            if ($urandom_range(0, 1))
                write_reg(rdl_pkg::CFG_MAX_LEVEL, {1'b0, pick_level()});
            if ($urandom_range(0, 1))
            begin
                case ($urandom_range(0, 4))
                    0: write_reg(rdl_pkg::CFG_STEP_SIZE, 17'd0);
                    1: write_reg(rdl_pkg::CFG_STEP_SIZE, 17'd1);
                    2: write_reg(rdl_pkg::CFG_STEP_SIZE, 17'h0FFFF);
                    3: write_reg(rdl_pkg::CFG_STEP_SIZE,
                                 rdl_pkg::CFG_DATA_BITS'($urandom_range(1, 20)));
                    default: write_reg(rdl_pkg::CFG_STEP_SIZE,
                                       {1'b0, rdl_pkg::LEVEL_BITS'($urandom)});
                endcase
            end
            if ($urandom_range(0, 1))
                write_reg(rdl_pkg::CFG_ACCEL_ENABLE,
                          rdl_pkg::CFG_DATA_BITS'($urandom_range(0, 1)));
            if ($urandom_range(0, 1))
                write_reg(rdl_pkg::CFG_DBL_PRESET, pick_preset());
            if ($urandom_range(0, 1))
                write_reg(rdl_pkg::CFG_HOLD_PRESET, pick_preset());

            no_idle = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 100);
            repeat (phase_len)
            begin
                sel = $urandom_range(0, 99);
                c = (sel < 55) ? rdl_pkg::CMD_ROTATE : (sel < 70) ? rdl_pkg::CMD_CLICK :
                    (sel < 85) ? rdl_pkg::CMD_DOUBLE : rdl_pkg::CMD_LONG;
                d = rdl_pkg::DELTA_BITS'($urandom_range(0, 3));
                sel = $urandom_range(0, 99);
                if (sel < 30)
                    knob_clock = knob_clock + $urandom_range(1, 30);
                else if (sel < 55)
                    knob_clock = knob_clock + $urandom_range(31, 80);
                else if (sel < 80)
                    knob_clock = knob_clock + $urandom_range(81, 500);
                else if (sel < 85)
                    knob_clock = '0;
                else if (sel < 92)
                    knob_clock = knob_clock - $urandom_range(1, 100);
                else
                    knob_clock = $urandom;
                push_request(c, d, knob_clock);
                items_sent++;
                if (predict_report(c, d, knob_clock, r))
                    pending_reports.push_back(r);
            end
        end

        evt_bus.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
